// ----- sv/jeq_pkg.sv -----
// Shared types, register indexes and sample kind codes for the joystick event qualifier.
package jeq_pkg;

  // Sample and event kind codes
  localparam logic [1:0] KIND_AXIS      = 2'd0;
  localparam logic [1:0] KIND_BUTTON    = 2'd1;
  localparam logic [1:0] KIND_HAT       = 2'd2;
  localparam logic [1:0] KIND_TRACKBALL = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_AUTO_REPEAT = 3'd0;
  localparam logic [2:0] REG_DELAY       = 3'd1;
  localparam logic [2:0] REG_DZ_01       = 3'd2;
  localparam logic [2:0] REG_DZ_23       = 3'd3;
  localparam logic [2:0] REG_SENS_01     = 3'd4;
  localparam logic [2:0] REG_SENS_23     = 3'd5;

  // Default channel counts and queue depth
  localparam int DEF_AXES       = 4;
  localparam int DEF_BUTTONS    = 16;
  localparam int DEF_HATS       = 4;
  localparam int DEF_TRACKBALLS = 2;
  localparam int QUEUE_DEPTH    = 2;

  // Decoded configuration, one 16-bit deadzone and sensitivity per axis
  typedef struct packed {
    logic             auto_repeat;
    logic [31:0]      repeat_delay;
    logic [3:0][15:0] deadzone;
    logic [3:0][15:0] sensitivity;
  } cfg_t;

  // A classified sample as it travels from the front to the back
  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         channel;
    logic signed [15:0] value;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [31:0]        time_ms;
    logic               below_dz;
  } item_t;

endpackage

// ----- sv/jeq_front.sv -----
// Front end: accepts samples, drops out-of-range channels and classifies the rest.
module jeq_front #(
  parameter int AXES       = jeq_pkg::DEF_AXES,
  parameter int BUTTONS    = jeq_pkg::DEF_BUTTONS,
  parameter int HATS       = jeq_pkg::DEF_HATS,
  parameter int TRACKBALLS = jeq_pkg::DEF_TRACKBALLS
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic [3:0]          in_channel,
  input  logic signed [15:0]  in_sample_value,
  input  logic signed [15:0]  in_motion_dx,
  input  logic signed [15:0]  in_motion_dy,
  input  logic [31:0]         in_time_ms,
  input  jeq_pkg::cfg_t       cfg,
  input  logic                q_full,
  output logic                q_push,
  output jeq_pkg::item_t      q_item
);
  import jeq_pkg::*;

  localparam logic [4:0] AXES_L  = 5'(AXES);
  localparam logic [4:0] BTN_L   = 5'(BUTTONS);
  localparam logic [4:0] HATS_L  = 5'(HATS);
  localparam logic [4:0] TRK_L   = 5'(TRACKBALLS);

  logic        in_range;
  logic [16:0] magnitude;

  // Channel range check per kind
  always_comb begin
    unique case (in_operation)
      KIND_AXIS:   in_range = {1'b0, in_channel} < AXES_L;
      KIND_BUTTON: in_range = {1'b0, in_channel} < BTN_L;
      KIND_HAT:    in_range = {1'b0, in_channel} < HATS_L;
      default:     in_range = {1'b0, in_channel} < TRK_L;
    endcase
  end

  // Axis magnitude; the most negative sample counts as 32768
  assign magnitude = in_sample_value[15] ? (17'd0 - {in_sample_value[15], in_sample_value})
                                         : {1'b0, in_sample_value};

  // Classified item: reported value and motion are fixed here by kind
  always_comb begin
    q_item          = '0;
    q_item.kind     = in_operation;
    q_item.channel  = in_channel;
    q_item.time_ms  = in_time_ms;
    unique case (in_operation)
      KIND_AXIS: begin
        q_item.below_dz = magnitude < {1'b0, cfg.deadzone[in_channel[1:0]]};
        q_item.value    = q_item.below_dz ? 16'sd0 : in_sample_value;
      end
      KIND_BUTTON: q_item.value = (in_sample_value != 16'sd0) ? 16'sd1 : 16'sd0;
      KIND_HAT:    q_item.value = {12'd0, in_sample_value[3:0]};
      default: begin
        q_item.dx = in_motion_dx;
        q_item.dy = in_motion_dy;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && in_range;

endmodule

// ----- sv/jeq_queue.sv -----
// Short queue of classified items between the front and the back.
module jeq_queue #(
  parameter int DEPTH = jeq_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jeq_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output jeq_pkg::item_t head
);
  import jeq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full   = count_r == CW'(DEPTH);
  assign valid  = count_r != '0;
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  // Pointer and occupancy updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Item storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- sv/jeq_back.sv -----
// Back end: per-channel state, change and repeat decisions, and the output register.
module jeq_back #(
  parameter int AXES    = jeq_pkg::DEF_AXES,
  parameter int BUTTONS = jeq_pkg::DEF_BUTTONS,
  parameter int HATS    = jeq_pkg::DEF_HATS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  jeq_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  jeq_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [3:0]         out_event_channel,
  output logic signed [15:0] out_event_value,
  output logic signed [15:0] out_event_dx,
  output logic signed [15:0] out_event_dy
);
  import jeq_pkg::*;

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int HW = (HATS > 1) ? $clog2(HATS) : 1;

  // Per-channel state
  logic signed [15:0] last_axis_r    [AXES];
  logic [31:0]        axis_stamp_r   [AXES];
  logic               last_button_r  [BUTTONS];
  logic [31:0]        button_stamp_r [BUTTONS];
  logic [3:0]         last_hat_r     [HATS];
  logic [31:0]        hat_stamp_r    [HATS];

  logic               out_valid_r, out_valid_nxt;
  item_t              out_item_r;

  logic [AW-1:0]      ax_idx;
  logic [BW-1:0]      bt_idx;
  logic [HW-1:0]      ht_idx;
  logic signed [15:0] last_val;
  logic [31:0]        stamp;
  logic               changed;
  logic [16:0]        diff;
  logic [16:0]        delta;
  logic               sens_ok;
  logic               due;
  logic               emit;
  logic               wr_value;
  logic               wr_stamp;
  logic               take;

  assign ax_idx = q_item.channel[AW-1:0];
  assign bt_idx = q_item.channel[BW-1:0];
  assign ht_idx = q_item.channel[HW-1:0];

  // Stored value and stamp of the addressed channel
  always_comb begin
    last_val = '0;
    stamp    = '0;
    unique case (q_item.kind)
      KIND_AXIS: begin
        last_val = last_axis_r[ax_idx];
        stamp    = axis_stamp_r[ax_idx];
      end
      KIND_BUTTON: begin
        last_val = {15'd0, last_button_r[bt_idx]};
        stamp    = button_stamp_r[bt_idx];
      end
      KIND_HAT: begin
        last_val = {12'd0, last_hat_r[ht_idx]};
        stamp    = hat_stamp_r[ht_idx];
      end
      default: begin
        last_val = '0;
        stamp    = '0;
      end
    endcase
  end

  // Change size for the sensitivity test, and elapsed time for a repeat
  assign changed = q_item.value != last_val;
  assign diff    = {last_val[15], last_val} - {q_item.value[15], q_item.value};
  assign delta   = diff[16] ? (17'd0 - diff) : diff;
  assign sens_ok = (q_item.kind != KIND_AXIS) ||
                   (delta >= {1'b0, cfg.sensitivity[q_item.channel[1:0]]});
  assign due     = (q_item.time_ms - stamp) >= cfg.repeat_delay;

  // Report and state update decision
  always_comb begin
    emit     = 1'b0;
    wr_value = 1'b0;
    wr_stamp = 1'b0;
    if (q_item.kind == KIND_TRACKBALL) begin
      emit = (q_item.dx != 16'sd0) || (q_item.dy != 16'sd0);
    end else if (q_item.below_dz) begin
      emit = 1'b1;
    end else if (changed) begin
      wr_value = 1'b1;
      wr_stamp = 1'b1;
      emit     = sens_ok;
    end else if (cfg.auto_repeat && (q_item.value != 16'sd0)) begin
      emit = due;
    end else begin
      wr_stamp = 1'b1;
    end
  end

  assign take  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = take;

  // Axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        last_axis_r[i]  <= '0;
        axis_stamp_r[i] <= '0;
      end
    end else if (take && (q_item.kind == KIND_AXIS)) begin
      for (int i = 0; i < AXES; i++) begin
        if (ax_idx == AW'(i)) begin
          if (wr_value) begin
            last_axis_r[i] <= q_item.value;
          end
          if (wr_stamp) begin
            axis_stamp_r[i] <= q_item.time_ms;
          end
        end
      end
    end
  end

  // Button state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUTTONS; i++) begin
        last_button_r[i]  <= 1'b0;
        button_stamp_r[i] <= '0;
      end
    end else if (take && (q_item.kind == KIND_BUTTON)) begin
      for (int i = 0; i < BUTTONS; i++) begin
        if (bt_idx == BW'(i)) begin
          if (wr_value) begin
            last_button_r[i] <= q_item.value[0];
          end
          if (wr_stamp) begin
            button_stamp_r[i] <= q_item.time_ms;
          end
        end
      end
    end
  end

  // Hat state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HATS; i++) begin
        last_hat_r[i]  <= '0;
        hat_stamp_r[i] <= '0;
      end
    end else if (take && (q_item.kind == KIND_HAT)) begin
      for (int i = 0; i < HATS; i++) begin
        if (ht_idx == HW'(i)) begin
          if (wr_value) begin
            last_hat_r[i] <= q_item.value[3:0];
          end
          if (wr_stamp) begin
            hat_stamp_r[i] <= q_item.time_ms;
          end
        end
      end
    end
  end

  // Output register: loads a reported item, clears once the item is taken
  always_comb begin
    if (take) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_item_r <= q_item;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_item_r.kind;
  assign out_event_channel = out_item_r.channel;
  assign out_event_value   = out_item_r.value;
  assign out_event_dx      = out_item_r.dx;
  assign out_event_dy      = out_item_r.dy;

endmodule

// ----- sv/joystick_event_qualifier.sv -----
// Top level of the joystick event qualifier: configuration registers, front, queue and back.
// The block takes one polled sample (axis, button, hat or trackball) per item and sustains
// one item per clock cycle while the output is not stalled. An accepted item enters a
// two-entry queue; the back end reads, decides and writes the addressed channel's stored
// value and stamp, and a reported result goes from the queue head into the output register.
// That read, compare and write of per-channel state sets the rate.
// Samples on an out-of-range channel, and samples that raise no event, produce no output.
// Configuration registers must be written only while no item is in flight.
module joystick_event_qualifier #(
  parameter int AXES       = jeq_pkg::DEF_AXES,
  parameter int BUTTONS    = jeq_pkg::DEF_BUTTONS,
  parameter int HATS       = jeq_pkg::DEF_HATS,
  parameter int TRACKBALLS = jeq_pkg::DEF_TRACKBALLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_channel,
  input  logic signed [15:0] in_sample_value,
  input  logic signed [15:0] in_motion_dx,
  input  logic signed [15:0] in_motion_dy,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [3:0]         out_event_channel,
  output logic signed [15:0] out_event_value,
  output logic signed [15:0] out_event_dx,
  output logic signed [15:0] out_event_dy
);
  import jeq_pkg::*;

  logic        auto_repeat_r;
  logic [31:0] delay_r;
  logic [31:0] dz01_r;
  logic [31:0] dz23_r;
  logic [31:0] sens01_r;
  logic [31:0] sens23_r;
  cfg_t        cfg;

  logic        q_full;
  logic        q_push;
  item_t       q_push_item;
  logic        q_pop;
  logic        q_valid;
  item_t       q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_repeat_r <= 1'b0;
      delay_r       <= '0;
      dz01_r        <= '0;
      dz23_r        <= '0;
      sens01_r      <= '0;
      sens23_r      <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_AUTO_REPEAT: auto_repeat_r <= cfg_data[0];
        REG_DELAY:       delay_r       <= cfg_data;
        REG_DZ_01:       dz01_r        <= cfg_data;
        REG_DZ_23:       dz23_r        <= cfg_data;
        REG_SENS_01:     sens01_r      <= cfg_data;
        REG_SENS_23:     sens23_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Per-axis view of the packed registers
  assign cfg.auto_repeat  = auto_repeat_r;
  assign cfg.repeat_delay = delay_r;
  assign cfg.deadzone     = {dz23_r, dz01_r};
  assign cfg.sensitivity  = {sens23_r, sens01_r};

  jeq_front #(
    .AXES       (AXES),
    .BUTTONS    (BUTTONS),
    .HATS       (HATS),
    .TRACKBALLS (TRACKBALLS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_channel      (in_channel),
    .in_sample_value (in_sample_value),
    .in_motion_dx    (in_motion_dx),
    .in_motion_dy    (in_motion_dy),
    .in_time_ms      (in_time_ms),
    .cfg             (cfg),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_push_item)
  );

  jeq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  jeq_back #(
    .AXES    (AXES),
    .BUTTONS (BUTTONS),
    .HATS    (HATS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_valid           (q_valid),
    .q_item            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_event_channel (out_event_channel),
    .out_event_value   (out_event_value),
    .out_event_dx      (out_event_dx),
    .out_event_dy      (out_event_dy)
  );

endmodule

// ----- sv/jeq_checker.sv -----
// Port-level checks on the result channel of the joystick event qualifier, with its binding.
module jeq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_event_kind,
  input logic signed [15:0] out_event_value,
  input logic signed [15:0] out_event_dx,
  input logic signed [15:0] out_event_dy
);
  import jeq_pkg::*;

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // Button events carry only a pressed or released state
  a_button_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_BUTTON) |->
      (out_event_value == 16'sd0) || (out_event_value == 16'sd1))
    else $error("button event with a value other than 0 or 1");

  // Trackball events report motion only, and some motion
  a_trackball: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_TRACKBALL) |->
      (out_event_value == 16'sd0) && ((out_event_dx != 16'sd0) || (out_event_dy != 16'sd0)))
    else $error("trackball event without motion or with a value");

  // Non-trackball events carry no motion, and hats stay within four bits
  a_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind != KIND_TRACKBALL) |->
      (out_event_dx == 16'sd0) && (out_event_dy == 16'sd0) &&
      ((out_event_kind != KIND_HAT) || (out_event_value[15:4] == 12'd0)))
    else $error("motion on a non-trackball event or hat mask out of range");

endmodule

bind joystick_event_qualifier jeq_checker u_jeq_checker (.*);
